FILE: hw/rtl/bnc_pkg.sv
// bnc_pkg: shared types, constants and the code mapping for the 3x3 neighbour code block.
// Used by bnc_res_fifo and binary_neighbour_code_3x3. No dependencies.
package bnc_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int WIDTH_CMP_W   = 14;
    localparam int RQ_DEPTH      = 8;
    localparam int RQ_PTR_W      = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W      = $clog2(RQ_DEPTH + 1);

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd1024;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] code;
        logic       lof;
        logic       lor;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } res_pair_t;

    // window bit = column slot * 3 + row slot; slot 0 is left / top
    function automatic logic [7:0] code_of(input logic [8:0] w);
        return {w[8], w[5], w[2], w[7], w[1], w[6], w[3], w[0]};
    endfunction

endpackage

FILE: hw/rtl/bnc_res_fifo.sv
// bnc_res_fifo: result queue that takes up to two words a cycle and hands out one.
// Depends on bnc_pkg.
module bnc_res_fifo
    import bnc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  res_pair_t           push,
    output logic [RQ_CNT_W-1:0] level,
    output logic                m_valid,
    input  logic                m_ready,
    output res_t                head
);

    res_t                q_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0] count_reg, count_next;
    logic                pop;

    assign level   = count_reg;
    assign m_valid = (count_reg != '0);
    assign head    = q_mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(pop);
        count_next  = count_reg + RQ_CNT_W'(push.cnt) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            q_mem[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            q_mem[wr_ptr_reg + RQ_PTR_W'(1)] <= push.second;
        end
    end

endmodule

FILE: hw/rtl/binary_neighbour_code_3x3.sv
// binary_neighbour_code_3x3: streaming 3x3 binary neighbourhood code, top level.
// Depends on bnc_pkg and bnc_res_fifo.
//
// Usage: pixels of a frame enter in raster order on the s_ channel, one word each
// (s_command = pixel); after the frame, image_width flush words (s_command = flush)
// drain the last row. Each word yields zero, one or two code words on the m_ channel,
// the code of the pixel one row up and one column left, plus the row's last code at
// the last column. m_last_of_run marks the last code a word caused, m_last_of_frame
// the frame's final code. Flushes sent before the frame is complete are dropped.
// Width and height are written through cfg_we / cfg_addr / cfg_wdata by the user,
// only while idle (not enforced). A code passes stage 1, then the result queue.
// Throughput: one word per cycle. Each word reads both 1-bit line stores at stage 0;
// a pixel writes back from stage 1, and same-entry overlap is forwarded. The 8-entry
// result queue stops s_ready only when it backs up while m_ready is low.
// Reset: control, window and queue clear, width and height return to 1024; the line
// stores are not cleared, rows above the frame read as zero by row count.
module binary_neighbour_code_3x3
    import bnc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [7:0]            s_pixel_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_neighbour_code,
    output logic                  m_last_of_frame,
    output logic                  m_last_of_run,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    logic [AW-1:0]           col_reg, col_next;
    logic [AW-1:0]           drain_reg, drain_next;
    logic [HEIGHT_REG_W-1:0] row_reg, row_next;

    logic                    s1_valid_reg;
    logic                    s1_wr_reg;
    logic                    s1_drain_reg;
    logic [AW-1:0]           s1_col_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;
    logic                    s1_r1_reg;
    logic                    s1_r2_reg;
    logic                    s1_bit_reg;

    logic                    older_mem [MAX_WIDTH];
    logic                    newer_mem [MAX_WIDTH];
    logic                    rd_older_reg, rd_newer_reg;
    logic                    fwd_reg, fwd_older_reg, fwd_newer_reg;

    logic [8:0]              window_reg, window_next;

    logic                    accept, is_flush, row_full, drop;
    logic [AW-1:0]           wm1, base_col, cur_col;
    logic [HEIGHT_REG_W-1:0] cur_row;
    logic                    cur_last;

    logic                    top_raw, mid_raw, top_bit, mid_bit;
    logic [8:0]              win_base;
    logic                    wr_en, emit1, emit2;
    res_pair_t               push;
    logic [RQ_CNT_W-1:0]     level;
    res_t                    head;

    // stage 0: position of the incoming word
    always_comb begin
        if (width_reg == '0) begin
            wm1 = '0;
        end else if (WIDTH_CMP_W'(width_reg) > WIDTH_CMP_W'(MAX_WIDTH)) begin
            wm1 = AW'(MAX_WIDTH - 1);
        end else begin
            wm1 = AW'(WIDTH_CMP_W'(width_reg) - WIDTH_CMP_W'(1));
        end
        if (height_reg == '0) begin
            row_full = (row_reg != '0);
        end else begin
            row_full = (row_reg >= height_reg);
        end
        is_flush = (s_command == CMD_FLUSH);
        drop     = is_flush && !row_full;
        if (is_flush) begin
            base_col = drain_reg;
        end else if (row_full) begin
            base_col = '0;
        end else begin
            base_col = col_reg;
        end
        cur_col  = (base_col > wm1) ? wm1 : base_col;
        cur_row  = (!is_flush && row_full) ? '0 : row_reg;
        cur_last = (cur_col == wm1);
    end

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (is_flush) begin
            if (row_full) begin
                if (cur_last) begin
                    col_next   = '0;
                    row_next   = '0;
                    drain_next = '0;
                end else begin
                    drain_next = cur_col + AW'(1);
                end
            end
        end else begin
            if (row_full) begin
                drain_next = '0;
            end
            if (cur_last) begin
                col_next = '0;
                row_next = cur_row + HEIGHT_REG_W'(1);
            end else begin
                col_next = cur_col + AW'(1);
                row_next = cur_row;
            end
        end
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_WIDTH:  width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                CFG_IDX_HEIGHT: height_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept && !drop;
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                drain_reg <= drain_next;
            end
        end
    end

    // a flush shifts in a zero pixel
    always_ff @(posedge aclk) begin
        s1_wr_reg    <= !is_flush;
        s1_drain_reg <= is_flush;
        s1_col_reg   <= cur_col;
        s1_first_reg <= (cur_col == '0);
        s1_last_reg  <= cur_last;
        s1_r1_reg    <= (cur_row != '0);
        s1_r2_reg    <= (cur_row > HEIGHT_REG_W'(1));
        s1_bit_reg   <= !is_flush && (s_pixel_value != 8'd0);
    end

    // line stores: read at stage 0, written back from stage 1
    assign wr_en   = s1_valid_reg && s1_wr_reg;
    assign top_raw = fwd_reg ? fwd_older_reg : rd_older_reg;
    assign mid_raw = fwd_reg ? fwd_newer_reg : rd_newer_reg;

    always_ff @(posedge aclk) begin
        rd_older_reg <= older_mem[cur_col];
        rd_newer_reg <= newer_mem[cur_col];
        if (wr_en) begin
            older_mem[s1_col_reg] <= mid_raw;
            newer_mem[s1_col_reg] <= s1_bit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= wr_en && (s1_col_reg == cur_col);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_older_reg <= mid_raw;
        fwd_newer_reg <= s1_bit_reg;
    end

    // stage 1: window shift and code generation
    always_comb begin
        top_bit     = s1_r2_reg && top_raw;
        mid_bit     = s1_r1_reg && mid_raw;
        win_base    = s1_first_reg ? 9'd0 : window_reg;
        window_next = {s1_bit_reg, mid_bit, top_bit, win_base[8:3]};
        emit1       = s1_valid_reg && s1_r1_reg && !s1_first_reg;
        emit2       = s1_valid_reg && s1_r1_reg && s1_last_reg;

        push.cnt         = 2'(emit1) + 2'(emit2);
        push.second.code = code_of({3'b000, window_next[8:3]});
        push.second.lof  = s1_drain_reg;
        push.second.lor  = 1'b1;
        if (emit1) begin
            push.first.code = code_of(window_next);
            push.first.lof  = 1'b0;
            push.first.lor  = !emit2;
        end else begin
            push.first = push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (s1_valid_reg) begin
            window_reg <= window_next;
        end
    end

    assign s_ready = ({1'b0, level} + (RQ_CNT_W + 1)'(push.cnt))
                     <= (RQ_CNT_W + 1)'(RQ_DEPTH - 2);

    bnc_res_fifo u_res_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .level   (level),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_neighbour_code = head.code;
    assign m_last_of_frame  = head.lof;
    assign m_last_of_run    = head.lor;

endmodule

FILE: hw/rtl/bnc_checker.sv
// bnc_checker: port-level assertions for binary_neighbour_code_3x3, bound to the top level.
// Depends on nothing but the top level's port names.
module bnc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_neighbour_code,
    input logic       m_last_of_frame,
    input logic       m_last_of_run
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_neighbour_code)
                                && $stable(m_last_of_frame) && $stable(m_last_of_run))
        else $error("stalled result word changed");

    a_frame_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_frame |-> m_last_of_run)
        else $error("frame end not at end of run");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without input word two cycles before");

endmodule

bind binary_neighbour_code_3x3 bnc_checker u_bnc_checker (.*);

FILE: test/binary_neighbour_code_3x3_test.sv
// binary_neighbour_code_3x3_test: self-checking bench for the 3x3 binary neighbour code block.
// Streams raster frames with random stalls on both sides and checks each code word
// against an in-bench line-store predictor. Depends on bnc_pkg and the block's RTL.
module binary_neighbour_code_3x3_test;
    import bnc_pkg::*;

    localparam int RANDOM_WORDS  = 580;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 2_000_000;
    // window slot feeding each code bit: NW, N, NE, W, E, SW, S, SE
    localparam int NBR_SLOT [8] = '{0, 3, 6, 1, 7, 2, 5, 8};

    typedef struct packed {
        logic       cmd;
        logic [7:0] pix;
    } pixel_word_t;

    typedef struct packed {
        logic [7:0] code;
        logic       frame_end;
        logic       run_end;
    } code_word_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_command     = CMD_PIXEL;
    logic [7:0]            s_pixel_value = 8'd0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [7:0]            m_neighbour_code;
    logic                  m_last_of_frame;
    logic                  m_last_of_run;
    logic                  cfg_we        = 1'b0;
    logic                  cfg_addr      = CFG_IDX_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    pixel_word_t pending_words [$];
    code_word_t  expected_codes [$];
    int          error_count = 0;
    int          cycle_count = 0;

    // predictor state
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RST;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RST;
    logic        older_bits [MAX_WIDTH_DEF];
    logic        newer_bits [MAX_WIDTH_DEF];
    logic [8:0]  window     = '0;
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    int unsigned drain_pos  = 0;

    // stall control
    int          burst_left = 8;
    int          gap_left   = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    binary_neighbour_code_3x3 dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pixel_value    (s_pixel_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbour_code (m_neighbour_code),
        .m_last_of_frame  (m_last_of_frame),
        .m_last_of_run    (m_last_of_run),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return width_reg;
    endfunction

    function automatic logic [7:0] window_to_code(logic [8:0] win);
        logic [7:0] code;
        for (int i = 0; i < 8; i++) code[i] = win[NBR_SLOT[i]];
        return code;
    endfunction

    // shift one column (rows r-2, r-1, r) into the window and queue the finished codes
    function automatic void shift_column_in(int unsigned c, int unsigned r, logic pix,
                                            logic drain);
        logic top;
        logic mid;
        logic at_end;
        top    = (r >= 2) ? older_bits[c] : 1'b0;
        mid    = (r >= 1) ? newer_bits[c] : 1'b0;
        at_end = (c == active_width() - 1);
        if (c == 0) window = '0;
        window = {pix, mid, top, window[8:3]};
        if (r >= 1) begin
            if (c >= 1)
                expected_codes.push_back(code_word_t'{window_to_code(window), 1'b0, !at_end});
            if (at_end)
                expected_codes.push_back(code_word_t'{window_to_code(window >> 3), drain, 1'b1});
        end
    endfunction

    function automatic void predict_codes(logic cmd, logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        w = active_width();
        h = (height_reg == 0) ? 1 : height_reg;
        if (cmd == CMD_FLUSH) begin
            if (row_pos < h) return;
            c = (drain_pos > w - 1) ? w - 1 : drain_pos;
            shift_column_in(c, row_pos, 1'b0, 1'b1);
            if (c == w - 1) begin
                row_pos   = 0;
                col_pos   = 0;
                drain_pos = 0;
            end else begin
                drain_pos = c + 1;
            end
        end else begin
            if (row_pos >= h) begin
                row_pos   = 0;
                col_pos   = 0;
                drain_pos = 0;
            end
            c = (col_pos > w - 1) ? w - 1 : col_pos;
            shift_column_in(c, row_pos, pix != 0, 1'b0);
            older_bits[c] = newer_bits[c];
            newer_bits[c] = (pix != 0);
            if (c == w - 1) begin
                col_pos = 0;
                row_pos = (row_pos + 1) & 32'h1FFF;
            end else begin
                col_pos = c + 1;
            end
        end
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge aclk) begin
        pixel_word_t nxt;
        logic        present;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_codes(s_command, s_pixel_value);
            if (!s_valid || s_ready) begin
                present = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    nxt = pending_words.pop_front();
                    present = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_valid <= present;
                if (present) begin
                    s_command     <= nxt.cmd;
                    s_pixel_value <= nxt.pix;
                end
            end
        end
    end

    // monitor: checks code words, stalls on a rotating pattern
    always @(posedge aclk) begin
        code_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    $error("unexpected code word: neighbour_code %0h", m_neighbour_code);
                    error_count++;
                end else begin
                    want = expected_codes.pop_front();
                    if (m_neighbour_code !== want.code) begin
                        $error("neighbour_code: expected %0h, got %0h", want.code,
                               m_neighbour_code);
                        error_count++;
                    end
                    if (m_last_of_frame !== want.frame_end) begin
                        $error("last_of_frame: expected %0b, got %0b", want.frame_end,
                               m_last_of_frame);
                        error_count++;
                    end
                    if (m_last_of_run !== want.run_end) begin
                        $error("last_of_run: expected %0b, got %0b", want.run_end,
                               m_last_of_run);
                        error_count++;
                    end
                end
            end
            if (pattern_age == 0) begin
                pattern_age   = $urandom_range(16, 64);
                ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            pattern_age--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            m_ready <= ready_pattern[0];
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_word(logic cmd, logic [7:0] v);
        pending_words.push_back(pixel_word_t'{cmd, v});
    endtask

    function automatic logic [7:0] draw_pixel(int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    // sampled between edges so driver and monitor updates have landed
    task automatic settle();
        while (pending_words.size() != 0 || s_valid || expected_codes.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
        else height_reg = data;
    endtask

    // one frame in raster order, stray flushes mixed in, then the drain; returns words counted
    task automatic queue_frame(int w, int h, int zero_pct, int flushes, output int counted);
        counted = 0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(0, 39) == 0) push_word(CMD_FLUSH, 8'($urandom));
                push_word(CMD_PIXEL, draw_pixel(zero_pct));
                counted++;
            end
        end
        repeat (flushes) push_word(CMD_FLUSH, 8'($urandom));
        counted += flushes;
    endtask

    initial begin
        int                    random_words;
        int                    counted;
        int                    w_eff;
        int                    h_eff;
        int                    flushes;
        int                    pick;
        logic                  keep_cfg;
        logic [CFG_DATA_W-1:0] width_word;
        logic [CFG_DATA_W-1:0] height_word;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x2 frame: flush before any frame and mid-frame are dropped
        set_reg(CFG_IDX_WIDTH, 13'd3);
        set_reg(CFG_IDX_HEIGHT, 13'd2);
        push_word(CMD_FLUSH, 8'hFF);
        push_word(CMD_PIXEL, 8'hFF);
        push_word(CMD_PIXEL, 8'h00);
        push_word(CMD_PIXEL, 8'h01);
        push_word(CMD_FLUSH, 8'h00);
        push_word(CMD_PIXEL, 8'h80);
        push_word(CMD_PIXEL, 8'h00);
        push_word(CMD_PIXEL, 8'h7F);
        repeat (3) push_word(CMD_FLUSH, 8'hAA);
        settle();

        // zero registers clamp to a 1x1 frame
        set_reg(CFG_IDX_WIDTH, 13'd0);
        set_reg(CFG_IDX_HEIGHT, 13'd0);
        push_word(CMD_PIXEL, 8'h55);
        push_word(CMD_FLUSH, 8'h00);
        settle();

        // width lowered mid-row, then again mid-drain
        set_reg(CFG_IDX_WIDTH, 13'd6);
        set_reg(CFG_IDX_HEIGHT, 13'd3);
        repeat (9) push_word(CMD_PIXEL, draw_pixel(40));
        settle();
        set_reg(CFG_IDX_WIDTH, 13'd4);
        repeat (5) push_word(CMD_PIXEL, draw_pixel(40));
        repeat (2) push_word(CMD_FLUSH, 8'h00);
        settle();
        set_reg(CFG_IDX_WIDTH, 13'd2);
        push_word(CMD_FLUSH, 8'h00);
        settle();

        // single-column frame, many rows
        set_reg(CFG_IDX_WIDTH, 13'd1);
        set_reg(CFG_IDX_HEIGHT, 13'd40);
        queue_frame(1, 40, 50, 1, counted);

        random_words = 0;
        keep_cfg     = 1'b0;
        w_eff        = 1;
        h_eff        = 1;
        while (random_words < RANDOM_WORDS) begin
            // a frame left undrained keeps its geometry for the next one
            if (!keep_cfg) begin
                w_eff = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64)
                                                    : $urandom_range(1, 12);
                h_eff = $urandom_range(1, 6);
                width_word = {2'($urandom), 11'(w_eff)};
                if (w_eff == 1 && $urandom_range(0, 1) == 1) width_word[10:0] = '0;
                height_word = 13'(h_eff);
                if (h_eff == 1 && $urandom_range(0, 1) == 1) height_word = '0;
                settle();
                set_reg(CFG_IDX_WIDTH, width_word);
                set_reg(CFG_IDX_HEIGHT, height_word);
            end
            pick = $urandom_range(0, 9);
            if (pick < 8) flushes = w_eff;
            else if (pick == 8) flushes = $urandom_range(0, w_eff - 1);
            else flushes = 0;
            keep_cfg = (flushes < w_eff);
            queue_frame(w_eff, h_eff, $urandom_range(0, 4) * 25, flushes, counted);
            random_words += counted;
            if (!keep_cfg && $urandom_range(0, 5) == 0) push_word(CMD_FLUSH, 8'($urandom));
        end

        settle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: binary_neighbour_code_3x3.f
hw/rtl/bnc_pkg.sv
hw/rtl/bnc_res_fifo.sv
hw/rtl/binary_neighbour_code_3x3.sv
hw/rtl/bnc_checker.sv
test/binary_neighbour_code_3x3_test.sv
